// ===== rtl/core/rct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types and constants for the rectangle collision table.
// ----------------------------------------------------------------------------
package rct_pkg;
    localparam int MaxEntries = 64;
    localparam int IdxW = $clog2(MaxEntries);
    localparam int CntW = $clog2(MaxEntries + 1);

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_SETVAL = 3'd2;
    localparam logic [2:0] OP_MOVE   = 3'd3;
    localparam logic [2:0] OP_PQUERY = 3'd4;
    localparam logic [2:0] OP_AQUERY = 3'd5;
    localparam logic [2:0] OP_RSVD6  = 3'd6;
    localparam logic [2:0] OP_RSVD7  = 3'd7;

    localparam logic [0:0] ADDR_DEFAULT_VALUE = 1'd0;

    typedef struct packed {
        logic [2:0]  op;
        logic signed [15:0] key;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] size_w;
        logic signed [15:0] size_h;
        logic [7:0]  tag_value;
    } t_req;

    typedef struct packed {
        logic       hit;
        logic [7:0] value_out;
        logic       status;
        logic [6:0] entries_used;
    } t_rsp;

    // one stored rectangle
    typedef struct packed {
        logic signed [15:0] key;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] width;
        logic signed [15:0] height;
        logic [7:0]  tag;
        logic [31:0] stamp;
    } t_slot;

    typedef struct packed {
        logic hit;
        logic key_eq;
    } t_cmp;
endpackage

// ===== rtl/core/rct_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_req_if / rct_rsp_if
// Valid/ready channels carrying request and result words.
// ----------------------------------------------------------------------------
interface rct_req_if import rct_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rct_rsp_if import rct_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/rct_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rct_cmp
// Shared geometry compare unit: tests one stored slot against the request.
// ----------------------------------------------------------------------------
module rct_cmp import rct_pkg::*; (
    input  t_req  i_req,
    input  t_slot i_slot,
    output t_cmp  o_cmp
);
    logic signed [15:0] w_r, w_b, w_qx1, w_qy1;
    logic w_xs, w_ys, w_px, w_py;

    function automatic logic f_in(logic signed [15:0] v, logic signed [15:0] lo,
                                  logic signed [15:0] hi);
        f_in = (v >= lo) && (v <= hi);
    endfunction

    assign w_r   = i_slot.left + i_slot.width;
    assign w_b   = i_slot.top + i_slot.height;
    assign w_qx1 = i_req.pos_x + i_req.size_w;
    assign w_qy1 = i_req.pos_y + i_req.size_h;

    assign w_px = f_in(i_req.pos_x, i_slot.left, w_r);
    assign w_py = f_in(i_req.pos_y, i_slot.top, w_b);
    assign w_xs = f_in(i_slot.left, i_req.pos_x, w_qx1) || f_in(w_r, i_req.pos_x, w_qx1)
               || f_in(i_req.pos_x, i_slot.left, w_r) || f_in(w_qx1, i_slot.left, w_r);
    assign w_ys = f_in(i_slot.top, i_req.pos_y, w_qy1) || f_in(w_b, i_req.pos_y, w_qy1)
               || f_in(i_req.pos_y, i_slot.top, w_b) || f_in(w_qy1, i_slot.top, w_b);

    assign o_cmp.hit    = (i_req.op == OP_PQUERY) ? (w_px && w_py) : (w_xs && w_ys);
    assign o_cmp.key_eq = (i_slot.key == i_req.key);
endmodule

// ===== rtl/core/rectangle_obstacle_collision_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_obstacle_collision_table
// Table of tagged rectangles with insert, key ops and collision queries.
// ----------------------------------------------------------------------------
// Every operation walks all slots through one single-port slot memory: the
// sequencer alternates a registered read state and a compare and write-back
// state for each slot, then presents the result word. Input is not ready
// while an operation is in flight or its result is waiting; the result stays
// in an output register until taken.
module rectangle_obstacle_collision_table import rct_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rct_req_if.sink     s_req,
    rct_rsp_if.source   m_rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    t_slot r_mem [MaxEntries];
    logic [MaxEntries-1:0] r_valid;
    logic [1:0]  r_state;
    logic [IdxW-1:0] r_idx;
    logic [CntW-1:0] r_count;
    logic [31:0] r_stamp;
    logic [7:0]  r_default;
    t_req  r_req;
    t_slot r_rd;
    logic  r_found, r_done_ins;
    logic signed [15:0] r_bkey;
    logic [31:0] r_bstamp;
    logic [7:0]  r_bval;
    logic  r_ovalid;
    t_rsp  r_rsp;

    logic [IdxW-1:0] w_i;
    t_cmp  w_cmp;
    t_slot w_wr;
    logic  w_we, w_better, w_is_q, w_acc;

    assign w_i    = r_idx;
    assign w_is_q = (r_req.op == OP_PQUERY) || (r_req.op == OP_AQUERY);
    assign w_acc  = s_req.valid && s_req.ready;

    rct_cmp u_cmp (.i_req(r_req), .i_slot(r_rd), .o_cmp(w_cmp));

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_DEFAULT_VALUE) ? {24'd0, r_default} : 32'd0;
    assign s_req.ready = (r_state == ST_IDLE) && !r_ovalid;
    assign m_rsp.valid = r_ovalid;
    assign m_rsp.data  = r_rsp;

    assign w_better = !r_found || (r_rd.key < r_bkey) ||
                      ((r_rd.key == r_bkey) && (r_rd.stamp > r_bstamp));

    always_comb begin
        w_wr = r_rd;
        w_we = 1'b0;
        if (r_state == ST_EVAL) begin
            if (r_req.op == OP_INSERT) begin
                if (!r_valid[w_i] && !r_done_ins && (r_count < CntW'(MaxEntries))) begin
                    w_we = 1'b1;
                    w_wr.key = r_req.key;
                    w_wr.left = r_req.pos_x;
                    w_wr.top = r_req.pos_y;
                    w_wr.width = r_req.size_w;
                    w_wr.height = r_req.size_h;
                    w_wr.tag = r_req.tag_value;
                    w_wr.stamp = r_stamp;
                end
            end else if (r_valid[w_i] && w_cmp.key_eq) begin
                if (r_req.op == OP_SETVAL) begin
                    w_we = 1'b1;
                    w_wr.tag = r_req.tag_value;
                end else if (r_req.op == OP_MOVE) begin
                    w_we = 1'b1;
                    w_wr.left = r_rd.left + r_req.pos_x;
                    w_wr.top = r_rd.top + r_req.pos_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_rd <= r_mem[w_i];
        end
        if (w_we) begin
            r_mem[w_i] <= w_wr;
        end
        if (w_acc) begin
            r_req <= s_req.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= '0;
            r_idx <= '0;
            r_count <= '0;
            r_stamp <= '0;
            r_default <= '0;
            r_found <= 1'b0;
            r_done_ins <= 1'b0;
            r_ovalid <= 1'b0;
            r_bkey <= '0;
            r_bstamp <= '0;
            r_bval <= '0;
            r_rsp <= '0;
        end else begin
            if (psel && penable && pwrite && paddr[2] == ADDR_DEFAULT_VALUE) begin
                r_default <= pwdata[7:0];
            end
            if (m_rsp.valid && m_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        r_state <= ST_READ;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_done_ins <= 1'b0;
                    end
                end
                ST_READ: r_state <= ST_EVAL;
                ST_EVAL: begin
                    if (w_we && r_req.op == OP_INSERT) begin
                        r_valid[w_i] <= 1'b1;
                        r_done_ins <= 1'b1;
                        r_count <= r_count + 1'b1;
                        r_stamp <= r_stamp + 32'd1;
                    end
                    if (r_req.op == OP_DELETE && r_valid[w_i] && w_cmp.key_eq) begin
                        r_valid[w_i] <= 1'b0;
                        r_count <= r_count - 1'b1;
                    end
                    if (w_is_q && r_valid[w_i] && w_cmp.hit && w_better) begin
                        r_found <= 1'b1;
                        r_bkey <= r_rd.key;
                        r_bstamp <= r_rd.stamp;
                        r_bval <= r_rd.tag;
                    end
                    if (r_idx == IdxW'(MaxEntries - 1)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_state <= ST_READ;
                    end
                end
                ST_DONE: begin
                    r_state <= ST_IDLE;
                    r_ovalid <= 1'b1;
                    r_rsp.hit <= w_is_q && r_found;
                    r_rsp.value_out <= !w_is_q ? 8'd0 : (r_found ? r_bval : r_default);
                    r_rsp.status <= (r_req.op == OP_INSERT) &&
                                    (r_count >= CntW'(MaxEntries)) && !r_done_ins;
                    r_rsp.entries_used <= 7'(r_count);
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxEntries)) else $error("entry count overflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> r_state == ST_IDLE) else $error("result while busy");
    a_cnt_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> r_count == CntW'($countones(r_valid)))
        else $error("count mismatch");
endmodule
